/* rtl/rdpv_pkg.sv */
package rdpv_pkg;

  localparam int CordicIter = 30;
  localparam int CordicN = (CordicIter > 64) ? 64 : CordicIter;

  localparam logic [63:0] Pi60    = 64'h3243F6A8885A308D;
  localparam logic [63:0] GainQ61 = 64'd1400229935014726477;
  localparam logic [63:0] ConvG   = 64'd9377660428731700199;

  typedef struct packed {
    logic [31:0]        ra_angle;
    logic signed [31:0] dec_angle;
    logic signed [31:0] pm_ra;
    logic signed [31:0] pm_dec;
    logic               last_in;
  } rdpv_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [47:0] vel_x;
    logic signed [47:0] vel_y;
    logic signed [47:0] vel_z;
    logic               last_out;
  } rdpv_out_t;

  // floor(2^e / d) by restoring long division, elaboration only
  function automatic logic signed [63:0] pow2_div(input int e, input int d);
    logic [63:0] q;
    logic [63:0] rem;
    q = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], (b == e)};
      if (rem >= 64'(d)) begin
        rem = rem - 64'(d);
        q[b] = 1'b1;
      end
    end
    return $signed(q);
  endfunction

  // atan(2^-i) in Q2.61 from truncated series terms
  function automatic logic signed [63:0] atan_q61(input int i);
    logic signed [63:0] sum;
    logic signed [63:0] term;
    int e;
    sum = 64'sd0;
    if (i == 0) begin
      sum = $signed(Pi60 >> 1);
    end else begin
      for (int k = 0; k < 62; k++) begin
        e = 61 - i * (2 * k + 1);
        if (e >= 0) begin
          term = pow2_div(e, 2 * k + 1);
          sum = (k % 2 == 1) ? sum - term : sum + term;
        end
      end
    end
    return sum;
  endfunction

  // Q2.61 to Q2.30 with rounding and clamp to +-2^30
  function automatic logic signed [31:0] to_q30(input logic signed [63:0] v);
    logic signed [64:0] t;
    logic signed [33:0] r;
    t = 65'(v) + 65'sd1073741824;
    r = 34'(t >>> 31);
    if (r > 34'sd1073741824) r = 34'sd1073741824;
    if (r < -34'sd1073741824) r = -34'sd1073741824;
    return r[31:0];
  endfunction

  // Q30 x Q30 product back to Q30, rounded to nearest with ties up
  function automatic logic signed [31:0] rnd_q30(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd536870912;
    return 32'(t >>> 30);
  endfunction

endpackage

/* rtl/rdpv_sincos.sv */
// Unrolled rotation-mode CORDIC, one register stage per iteration.
module rdpv_sincos
  import rdpv_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        ang,
  output logic signed [31:0] co,
  output logic signed [31:0] si
);

  logic signed [63:0] x [CordicN+1];
  logic signed [63:0] y [CordicN+1];
  logic signed [63:0] z [CordicN+1];
  logic [1:0]         q [CordicN+1];
  logic [29:0]        r;
  logic [63:0]        z0;
  logic signed [31:0] c_q, s_q;

  assign r  = ang[29:0];
  assign z0 = ((64'(r) * 64'(Pi60[63:32])) << 2) + ((64'(r) * 64'(Pi60[31:0])) >> 30);

  // load the angle reduction stage
  always_ff @(posedge clk) begin
    if (en) begin
      x[0] <= $signed(GainQ61);
      y[0] <= 64'sd0;
      z[0] <= $signed(z0);
      q[0] <= ang[31:30];
    end
  end

  // rotate one micro-step per stage
  for (genvar i = 0; i < CordicN; i++) begin : g_it
    localparam logic signed [63:0] At = atan_q61(i);
    always_ff @(posedge clk) begin
      if (en) begin
        q[i+1] <= q[i];
        if (!z[i][63]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - At;
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + At;
        end
      end
    end
  end

  // round and unfold the quadrant
  assign c_q = to_q30(x[CordicN]);
  assign s_q = to_q30(y[CordicN]);

  always_ff @(posedge clk) begin
    if (en) begin
      case (q[CordicN])
        2'd0:    begin co <= c_q;  si <= s_q;  end
        2'd1:    begin co <= -s_q; si <= c_q;  end
        2'd2:    begin co <= -c_q; si <= -s_q; end
        default: begin co <= s_q;  si <= -c_q; end
      endcase
    end
  end

endmodule

/* rtl/radec_to_position_velocity_vector.sv */
// One source enters per clock while the pipeline is not held; its result passes
// the unrolled CORDIC, one stage per iteration, then the product stages. Ready
// falls only when the output stage is full and not taken, and the whole
// pipeline then holds.
module radec_to_position_velocity_vector
  import rdpv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  rdpv_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output rdpv_out_t out_data
);

  localparam int Lat = CordicN + 7;

  logic en;
  logic [Lat-1:0] vld;
  logic signed [31:0] ca, sa, cd, sd;

  // delay line for the passthrough fields while the CORDIC runs
  logic signed [31:0] pmra_d [CordicN+2];
  logic signed [31:0] pmdec_d [CordicN+2];
  logic               last_d [CordicN+2];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Lat-2:0], in_valid};
    end
  end
  assign out_valid = vld[Lat-1];

  rdpv_sincos u_ra (.clk(clk), .en(en), .ang(in_data.ra_angle), .co(ca), .si(sa));
  rdpv_sincos u_dec (.clk(clk), .en(en), .ang(in_data.dec_angle), .co(cd), .si(sd));

  always_ff @(posedge clk) begin
    if (en) begin
      pmra_d[0]  <= in_data.pm_ra;
      pmdec_d[0] <= in_data.pm_dec;
      last_d[0]  <= in_data.last_in;
      for (int i = 1; i < CordicN + 2; i++) begin
        pmra_d[i]  <= pmra_d[i-1];
        pmdec_d[i] <= pmdec_d[i-1];
        last_d[i]  <= last_d[i-1];
      end
    end
  end

  // stage A: trig products
  logic signed [31:0] a_ca, a_sa, a_cd, a_sd, a_pmra, a_pmdec;
  logic signed [63:0] a_casd, a_sasd, a_cacd, a_sacd;
  logic               a_last;
  always_ff @(posedge clk) begin
    if (en) begin
      a_ca <= ca; a_sa <= sa; a_cd <= cd; a_sd <= sd;
      a_pmra <= pmra_d[CordicN+1]; a_pmdec <= pmdec_d[CordicN+1];
      a_last <= last_d[CordicN+1];
      a_casd <= 64'(ca) * 64'(sd);
      a_sasd <= 64'(sa) * 64'(sd);
      a_cacd <= 64'(ca) * 64'(cd);
      a_sacd <= 64'(sa) * 64'(cd);
    end
  end

  // stage B: proper motion products and rounded positions
  logic signed [63:0] b_p1, b_p2, b_p3, b_p4, b_p5;
  logic signed [31:0] b_px, b_py, b_pz;
  logic               b_last;
  always_ff @(posedge clk) begin
    if (en) begin
      b_p1 <= 64'(a_pmra) * 64'(a_sa);
      b_p2 <= 64'(a_pmdec) * 64'(rnd_q30(a_casd));
      b_p3 <= 64'(a_pmra) * 64'(a_ca);
      b_p4 <= 64'(a_pmdec) * 64'(rnd_q30(a_sasd));
      b_p5 <= 64'(a_pmdec) * 64'(a_cd);
      b_px <= rnd_q30(a_cacd);
      b_py <= rnd_q30(a_sacd);
      b_pz <= a_sd;
      b_last <= a_last;
    end
  end

  // stage C: sums and magnitudes
  logic [63:0] c_m [3];
  logic        c_n [3];
  logic signed [63:0] c_s [3];
  logic signed [31:0] c_px, c_py, c_pz;
  logic               c_last;
  always_comb begin
    c_s[0] = -b_p1 - b_p2;
    c_s[1] = b_p3 - b_p4;
    c_s[2] = b_p5;
  end
  logic [63:0] cm_r [3];
  logic        cn_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        cn_r[j] <= c_s[j][63];
        cm_r[j] <= c_s[j][63] ? 64'(-c_s[j]) : 64'(c_s[j]);
      end
      c_px <= b_px; c_py <= b_py; c_pz <= b_pz; c_last <= b_last;
    end
  end
  assign c_m = cm_r;
  assign c_n = cn_r;

  // stage D: 32x32 partial products of |S| * G
  logic [63:0] d_p00 [3], d_p01 [3], d_p10 [3], d_p11 [3];
  logic        d_n [3];
  logic signed [31:0] d_px, d_py, d_pz;
  logic               d_last;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        d_p00[j] <= 64'(c_m[j][31:0]) * 64'(ConvG[31:0]);
        d_p01[j] <= 64'(c_m[j][31:0]) * 64'(ConvG[63:32]);
        d_p10[j] <= 64'(c_m[j][63:32]) * 64'(ConvG[31:0]);
        d_p11[j] <= 64'(c_m[j][63:32]) * 64'(ConvG[63:32]);
        d_n[j]   <= c_n[j];
      end
      d_px <= c_px; d_py <= c_py; d_pz <= c_pz; d_last <= c_last;
    end
  end

  // stage E: high word, round, saturate
  logic [63:0] e_mid, e_hi, e_m;
  logic signed [47:0] e_v [3];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      e_mid = (d_p00[j] >> 32) + {32'd0, d_p01[j][31:0]} + {32'd0, d_p10[j][31:0]};
      e_hi  = d_p11[j] + (d_p01[j] >> 32) + (d_p10[j] >> 32) + (e_mid >> 32);
      e_m   = (e_hi + 64'd524288) >> 20;
      if (d_n[j]) begin
        e_v[j] = (e_m >= 64'h8000_0000_0000) ? 48'sh8000_0000_0000 : 48'(-e_m);
      end else begin
        e_v[j] = (e_m >= 64'h8000_0000_0000) ? 48'sh7FFF_FFFF_FFFF : e_m[47:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.pos_x <= d_px;
      out_data.pos_y <= d_py;
      out_data.pos_z <= d_pz;
      out_data.vel_x <= e_v[0];
      out_data.vel_y <= e_v[1];
      out_data.vel_z <= e_v[2];
      out_data.last_out <= d_last;
    end
  end

  // check no hold while drained, no result dropped, no request lost
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready) else $error("stall with output taken");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  a_entry: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> vld[0]) else $error("request lost");

endmodule
